// ===== hw/rtl/lmq_pkg.sv =====
// Shared types and constants for the linked multi-queue manager.
// Holds the transaction structs, command and status codes and parameter defaults.
// No dependencies.
package lmq_pkg;

   localparam int NUM_QUEUES_DEF   = 64;
   localparam int POOL_ENTRIES_DEF = 256;
   localparam int ID_BITS_DEF      = 8;

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_POP    = 2'd1;
   localparam logic [1:0] CMD_PURGE  = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [5:0] queue_sel;
      logic [7:0] proc_id;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] popped_id;
      logic [8:0] purged_count;
      logic       now_empty;
   } rsp_type;

   typedef struct packed {
      logic link_we;
      logic owner_we;
   } pool_ctl_type;

   typedef struct packed {
      logic head_we;
      logic tail_we;
      logic ne_set;
      logic ne_clr;
   } qtab_ctl_type;

endpackage

// ===== hw/rtl/lmq_pool.sv =====
// Link entry pool: next-link and owner-id memories with registered reads.
// Entries at or above the high-water mark read back their reset link without a clearing pass.
// Depends on lmq_pkg.
module lmq_pool #(
   parameter int POOL_ENTRIES = lmq_pkg::POOL_ENTRIES_DEF,
   parameter int ID_BITS      = lmq_pkg::ID_BITS_DEF,
   localparam int PW          = $clog2(POOL_ENTRIES)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lmq_pkg::pool_ctl_type ctl,
   input  logic [PW-1:0]        rd_addr,
   input  logic [PW-1:0]        link_wr_addr,
   input  logic [PW-1:0]        link_wr_data,
   input  logic [PW-1:0]        owner_wr_addr,
   input  logic [ID_BITS-1:0]   owner_wr_data,
   output logic [PW-1:0]        link_rd,
   output logic [ID_BITS-1:0]   owner_rd
);
   import lmq_pkg::*;

   localparam int WW = PW + 1;

   logic [PW-1:0]      link_mem  [POOL_ENTRIES];
   logic [ID_BITS-1:0] owner_mem [POOL_ENTRIES];

   logic [PW-1:0]      link_q_ff;
   logic [ID_BITS-1:0] owner_q_ff;
   logic [PW-1:0]      rd_addr_ff;
   logic               fresh_ff;
   logic [WW-1:0]      wm_ff;
   logic [WW-1:0]      wm_in;

   always_ff @(posedge clock) begin
      if (ctl.link_we) begin
         link_mem[link_wr_addr] <= link_wr_data;
      end
      if (ctl.owner_we) begin
         owner_mem[owner_wr_addr] <= owner_wr_data;
      end
      link_q_ff  <= link_mem[rd_addr];
      owner_q_ff <= owner_mem[rd_addr];
      rd_addr_ff <= rd_addr;
      fresh_ff   <= ({1'b0, rd_addr} >= wm_ff);
   end

   // Every allocation takes the next fresh entry or a recycled one, so entries
   // at or above the mark have never had their link written.
   always_comb begin
      wm_in = wm_ff;
      if (ctl.owner_we && ({1'b0, owner_wr_addr} >= wm_ff)) begin
         wm_in = {1'b0, owner_wr_addr} + WW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wm_ff <= '0;
      end else begin
         wm_ff <= wm_in;
      end
   end

   always_comb begin
      if (fresh_ff) begin
         link_rd = (rd_addr_ff == PW'(POOL_ENTRIES - 1)) ? '0 : rd_addr_ff + PW'(1);
      end else begin
         link_rd = link_q_ff;
      end
   end

   assign owner_rd = owner_q_ff;

endmodule

// ===== hw/rtl/lmq_qtab.sv =====
// Queue table: head and tail pointer memories and the per-queue non-empty flags.
// Depends on lmq_pkg.
module lmq_qtab #(
   parameter int NUM_QUEUES   = lmq_pkg::NUM_QUEUES_DEF,
   parameter int POOL_ENTRIES = lmq_pkg::POOL_ENTRIES_DEF,
   localparam int QW          = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
   localparam int PW          = $clog2(POOL_ENTRIES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lmq_pkg::qtab_ctl_type ctl,
   input  logic [QW-1:0]         rd_addr,
   input  logic [QW-1:0]         wr_addr,
   input  logic [PW-1:0]         head_wr_data,
   input  logic [PW-1:0]         tail_wr_data,
   output logic [PW-1:0]         head_rd,
   output logic [PW-1:0]         tail_rd,
   output logic                  ne
);
   import lmq_pkg::*;

   logic [PW-1:0]         head_mem [NUM_QUEUES];
   logic [PW-1:0]         tail_mem [NUM_QUEUES];
   logic [PW-1:0]         head_q_ff;
   logic [PW-1:0]         tail_q_ff;
   logic [NUM_QUEUES-1:0] ne_ff;
   logic [NUM_QUEUES-1:0] ne_in;

   always_ff @(posedge clock) begin
      if (ctl.head_we) begin
         head_mem[wr_addr] <= head_wr_data;
      end
      if (ctl.tail_we) begin
         tail_mem[wr_addr] <= tail_wr_data;
      end
      head_q_ff <= head_mem[rd_addr];
      tail_q_ff <= tail_mem[rd_addr];
   end

   always_comb begin
      ne_in = ne_ff;
      if (ctl.ne_set) begin
         ne_in[wr_addr] = 1'b1;
      end
      if (ctl.ne_clr) begin
         ne_in[wr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ne_ff <= '0;
      end else begin
         ne_ff <= ne_in;
      end
   end

   assign head_rd = head_q_ff;
   assign tail_rd = tail_q_ff;
   assign ne      = ne_ff[wr_addr];

endmodule

// ===== hw/rtl/lmq_ctrl.sv =====
// Sequencer for the queue manager: free-list registers, command decode and the
// purge walk that compares one pool entry per cycle. Depends on lmq_pkg.
module lmq_ctrl #(
   parameter int NUM_QUEUES   = lmq_pkg::NUM_QUEUES_DEF,
   parameter int POOL_ENTRIES = lmq_pkg::POOL_ENTRIES_DEF,
   parameter int ID_BITS      = lmq_pkg::ID_BITS_DEF,
   localparam int QW          = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
   localparam int PW          = $clog2(POOL_ENTRIES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  lmq_pkg::req_type      req_data,
   output logic                  busy,
   output logic                  fin_valid,
   output lmq_pkg::rsp_type      fin_data,
   input  logic                  out_free,
   output lmq_pkg::qtab_ctl_type qt_ctl,
   output logic [QW-1:0]         qt_rd_addr,
   output logic [QW-1:0]         qt_wr_addr,
   output logic [PW-1:0]         qt_head_wd,
   output logic [PW-1:0]         qt_tail_wd,
   input  logic [PW-1:0]         head_rd,
   input  logic [PW-1:0]         tail_rd,
   input  logic                  ne,
   output lmq_pkg::pool_ctl_type pl_ctl,
   output logic [PW-1:0]         pl_rd_addr,
   output logic [PW-1:0]         link_wr_addr,
   output logic [PW-1:0]         link_wr_data,
   output logic [PW-1:0]         owner_wr_addr,
   output logic [ID_BITS-1:0]    owner_wr_data,
   input  logic [PW-1:0]         link_rd,
   input  logic [ID_BITS-1:0]    owner_rd
);
   import lmq_pkg::*;

   localparam int CW = PW + 1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LOOK = 5'b00010,
      ST_POP  = 5'b00100,
      ST_WALK = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         cmd_ff, cmd_in;
   logic [5:0]         q_ff, q_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic               oor_ff, oor_in;
   logic [1:0]         status_ff, status_in;
   logic [ID_BITS-1:0] popped_ff, popped_in;
   logic [CW-1:0]      purged_ff, purged_in;
   logic [PW-1:0]      free_head_ff, free_head_in;
   logic [CW-1:0]      free_count_ff, free_count_in;
   logic [PW-1:0]      cur_ff, cur_in;
   logic [PW-1:0]      tail_ff, tail_in;
   logic [PW-1:0]      prev_ff, prev_in;
   logic [PW-1:0]      fix_next_ff, fix_next_in;
   logic               have_prev_ff, have_prev_in;
   logic               pend_ff, pend_in;
   logic [PW-1:0]      steps_ff, steps_in;

   logic [QW-1:0]      q_idx;
   logic [PW-1:0]      nxt;
   logic               last;
   logic               stop;
   logic               match;
   logic [CW-1:0]      count_inc;

   assign q_idx     = QW'(q_ff);
   assign nxt       = link_rd;
   assign last      = (cur_ff == tail_ff);
   assign stop      = last || (steps_ff == PW'(POOL_ENTRIES - 1));
   assign match     = (owner_rd == id_ff);
   assign count_inc = (free_count_ff < CW'(POOL_ENTRIES)) ?
                      free_count_ff + CW'(1) : free_count_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      q_in          = q_ff;
      id_in         = id_ff;
      oor_in        = oor_ff;
      status_in     = status_ff;
      popped_in     = popped_ff;
      purged_in     = purged_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      cur_in        = cur_ff;
      tail_in       = tail_ff;
      prev_in       = prev_ff;
      fix_next_in   = fix_next_ff;
      have_prev_in  = have_prev_ff;
      pend_in       = pend_ff;
      steps_in      = steps_ff;
      qt_ctl        = '0;
      pl_ctl        = '0;
      qt_rd_addr    = q_idx;
      qt_head_wd    = free_head_ff;
      qt_tail_wd    = free_head_ff;
      pl_rd_addr    = free_head_ff;
      link_wr_addr  = cur_ff;
      link_wr_data  = free_head_ff;
      owner_wr_addr = free_head_ff;
      owner_wr_data = id_ff;
      fin_valid     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // The pool read of the free-list head is issued here so an append
            // has the follower link on the next cycle.
            qt_rd_addr = QW'(req_data.queue_sel);
            if (req_valid) begin
               cmd_in    = req_data.cmd;
               q_in      = req_data.queue_sel;
               id_in     = ID_BITS'(req_data.proc_id);
               oor_in    = (32'(req_data.queue_sel) >= 32'(NUM_QUEUES));
               status_in = STAT_OK;
               popped_in = '0;
               purged_in = '0;
               pend_in   = 1'b0;
               state_in  = (32'(req_data.queue_sel) >= 32'(NUM_QUEUES)) ? ST_FIN : ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_FIN;
            case (cmd_ff)
               CMD_APPEND: begin
                  if (free_count_ff == '0) begin
                     status_in = STAT_FULL;
                  end else begin
                     pl_ctl.owner_we = 1'b1;
                     free_head_in    = link_rd;
                     free_count_in   = free_count_ff - CW'(1);
                     if (ne) begin
                        pl_ctl.link_we = 1'b1;
                        link_wr_addr   = tail_rd;
                     end else begin
                        qt_ctl.head_we = 1'b1;
                     end
                     qt_ctl.tail_we = 1'b1;
                     qt_ctl.ne_set  = 1'b1;
                  end
               end
               CMD_POP: begin
                  if (!ne) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     pl_rd_addr = head_rd;
                     cur_in     = head_rd;
                     tail_in    = tail_rd;
                     state_in   = ST_POP;
                  end
               end
               CMD_PURGE: begin
                  if (ne) begin
                     pl_rd_addr   = head_rd;
                     cur_in       = head_rd;
                     tail_in      = tail_rd;
                     have_prev_in = 1'b0;
                     steps_in     = '0;
                     state_in     = ST_WALK;
                  end
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_POP: begin
            popped_in = owner_rd;
            if (last) begin
               qt_ctl.ne_clr = 1'b1;
            end else begin
               qt_ctl.head_we = 1'b1;
               qt_head_wd     = nxt;
            end
            pl_ctl.link_we = 1'b1;
            free_head_in   = cur_ff;
            free_count_in  = count_inc;
            state_in       = ST_FIN;
         end
         ST_WALK: begin
            if (match) begin
               if (have_prev_ff) begin
                  // The survivor's link is written once the run of matches ends,
                  // since the link port is busy releasing entries meanwhile.
                  fix_next_in = nxt;
                  pend_in     = 1'b1;
                  if (last) begin
                     qt_ctl.tail_we = 1'b1;
                     qt_tail_wd     = prev_ff;
                  end
               end else begin
                  qt_ctl.head_we = 1'b1;
                  qt_head_wd     = nxt;
               end
               pl_ctl.link_we = 1'b1;
               free_head_in   = cur_ff;
               free_count_in  = count_inc;
               purged_in      = purged_ff + CW'(1);
            end else begin
               if (pend_ff) begin
                  pl_ctl.link_we = 1'b1;
                  link_wr_addr   = prev_ff;
                  link_wr_data   = fix_next_ff;
               end
               pend_in      = 1'b0;
               prev_in      = cur_ff;
               have_prev_in = 1'b1;
            end
            if (stop) begin
               if (!have_prev_ff && match) begin
                  qt_ctl.ne_clr = 1'b1;
               end
               state_in = ST_FIN;
            end else begin
               cur_in     = nxt;
               pl_rd_addr = nxt;
               steps_in   = steps_ff + PW'(1);
            end
         end
         ST_FIN: begin
            fin_valid = 1'b1;
            if (pend_ff) begin
               pl_ctl.link_we = 1'b1;
               link_wr_addr   = prev_ff;
               link_wr_data   = fix_next_ff;
            end
            if (out_free) begin
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_head_ff  <= '0;
         free_count_ff <= CW'(POOL_ENTRIES);
         pend_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         pend_ff       <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      q_ff         <= q_in;
      id_ff        <= id_in;
      oor_ff       <= oor_in;
      status_ff    <= status_in;
      popped_ff    <= popped_in;
      purged_ff    <= purged_in;
      cur_ff       <= cur_in;
      tail_ff      <= tail_in;
      prev_ff      <= prev_in;
      fix_next_ff  <= fix_next_in;
      have_prev_ff <= have_prev_in;
      steps_ff     <= steps_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign qt_wr_addr = q_idx;

   always_comb begin
      fin_data              = '0;
      fin_data.status       = status_ff;
      fin_data.popped_id    = 8'(popped_ff);
      fin_data.purged_count = 9'(purged_ff);
      fin_data.now_empty    = oor_ff | ~ne;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= CW'(POOL_ENTRIES))
      else $error("free count above pool size");

   a_append_alloc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK && cmd_ff == CMD_APPEND && free_count_ff != '0)
      |=> free_count_ff == $past(free_count_ff) - CW'(1))
      else $error("append did not take one free entry");

   a_pend_prev: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> have_prev_ff)
      else $error("pending link fix without a surviving entry");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && status_ff == STAT_EMPTY) |-> cmd_ff == CMD_POP)
      else $error("empty status on a command other than remove head");

endmodule

// ===== hw/rtl/linked_multi_queue_manager_unit.sv =====
// Linked multi-queue manager. Append and unknown commands pass the lookup state, then
// finish; remove-head adds a pop state, and purge of a non-empty queue a walk through
// the link memory, one registered read per entry, that sets purge time. Out-of-range
// queues skip lookup. Next transaction is taken the cycle after the result registers.
// Synchronous reset empties every queue and frees the whole pool at once; there is no
// clearing pass, since unused pool entries are tracked by a high-water mark.
module linked_multi_queue_manager_unit #(
   parameter int NUM_QUEUES   = lmq_pkg::NUM_QUEUES_DEF,
   parameter int POOL_ENTRIES = lmq_pkg::POOL_ENTRIES_DEF,
   parameter int ID_BITS      = lmq_pkg::ID_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lmq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lmq_pkg::rsp_type rsp_data
);
   import lmq_pkg::*;

   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PW = $clog2(POOL_ENTRIES);

   logic               busy;
   logic               fin_valid;
   rsp_type            fin_data;
   logic               out_free;
   qtab_ctl_type       qt_ctl;
   logic [QW-1:0]      qt_rd_addr;
   logic [QW-1:0]      qt_wr_addr;
   logic [PW-1:0]      qt_head_wd;
   logic [PW-1:0]      qt_tail_wd;
   logic [PW-1:0]      head_rd;
   logic [PW-1:0]      tail_rd;
   logic               ne;
   pool_ctl_type       pl_ctl;
   logic [PW-1:0]      pl_rd_addr;
   logic [PW-1:0]      link_wr_addr;
   logic [PW-1:0]      link_wr_data;
   logic [PW-1:0]      owner_wr_addr;
   logic [ID_BITS-1:0] owner_wr_data;
   logic [PW-1:0]      link_rd;
   logic [ID_BITS-1:0] owner_rd;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;

   lmq_ctrl #(
      .NUM_QUEUES   (NUM_QUEUES),
      .POOL_ENTRIES (POOL_ENTRIES),
      .ID_BITS      (ID_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data      (req_data),
      .busy          (busy),
      .fin_valid     (fin_valid),
      .fin_data      (fin_data),
      .out_free      (out_free),
      .qt_ctl        (qt_ctl),
      .qt_rd_addr    (qt_rd_addr),
      .qt_wr_addr    (qt_wr_addr),
      .qt_head_wd    (qt_head_wd),
      .qt_tail_wd    (qt_tail_wd),
      .head_rd       (head_rd),
      .tail_rd       (tail_rd),
      .ne            (ne),
      .pl_ctl        (pl_ctl),
      .pl_rd_addr    (pl_rd_addr),
      .link_wr_addr  (link_wr_addr),
      .link_wr_data  (link_wr_data),
      .owner_wr_addr (owner_wr_addr),
      .owner_wr_data (owner_wr_data),
      .link_rd       (link_rd),
      .owner_rd      (owner_rd)
   );

   lmq_qtab #(
      .NUM_QUEUES   (NUM_QUEUES),
      .POOL_ENTRIES (POOL_ENTRIES)
   ) u_qtab (
      .clock        (clock),
      .reset        (reset),
      .ctl          (qt_ctl),
      .rd_addr      (qt_rd_addr),
      .wr_addr      (qt_wr_addr),
      .head_wr_data (qt_head_wd),
      .tail_wr_data (qt_tail_wd),
      .head_rd      (head_rd),
      .tail_rd      (tail_rd),
      .ne           (ne)
   );

   lmq_pool #(
      .POOL_ENTRIES (POOL_ENTRIES),
      .ID_BITS      (ID_BITS)
   ) u_pool (
      .clock         (clock),
      .reset         (reset),
      .ctl           (pl_ctl),
      .rd_addr       (pl_rd_addr),
      .link_wr_addr  (link_wr_addr),
      .link_wr_data  (link_wr_data),
      .owner_wr_addr (owner_wr_addr),
      .owner_wr_data (owner_wr_data),
      .link_rd       (link_rd),
      .owner_rd      (owner_rd)
   );

   // The output register frees up in the same cycle its transaction is taken.
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = (fin_valid && out_free) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid && out_free) begin
         rsp_data_ff <= fin_data;
      end
   end

   assign req_stall = busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
